>>> rtl/core/omdfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package omdfp_pkg;

   localparam logic [1:0]  KIND_SHIFT = 2'd0;
   localparam logic [1:0]  KIND_TURN  = 2'd1;
   localparam logic [1:0]  KIND_TEST  = 2'd2;

   localparam logic [6:0]  MAX_SPEED_RESET = 7'd100;
   localparam logic signed [8:0] PCT_LIMIT = 9'sd100;
   // ceil(2^24 / 25): 16384*s/100 == (s * RECIP_25) >> 12 for 0 <= s <= 100
   localparam logic [19:0] RECIP_25 = 20'd671089;
   localparam logic [2:0]  Q_TOP_BIT = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULT,
      ST_SQ_A,
      ST_TRIAL_A,
      ST_TEST_A,
      ST_SQ_B,
      ST_TRIAL_B,
      ST_TEST_B,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic mult;
      logic square;
      logic trial;
      logic test;
      logic write;
      logic use_b;
   } cmd_type;

   typedef struct packed {
      logic is_shift;
      logic last_bit;
      logic out_busy;
   } status_type;

   // saturate a percentage to +-100 and scale to a current word
   function automatic logic [15:0] pct_to_word(input logic signed [8:0] s);
      logic signed [8:0] s_abs;
      logic [6:0]        mag;
      logic [26:0]       prod;
      logic [15:0]       w;
      s_abs = s[8] ? -s : s;
      if ((s > PCT_LIMIT) || (s < -PCT_LIMIT)) begin
         mag = 7'd100;
      end else begin
         mag = s_abs[6:0];
      end
      prod = 27'(mag) * 27'(RECIP_25);
      w = {1'b0, prod[26:12]};
      if (s[8]) begin
         w = 16'(-w);
      end
      return w;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/omdfp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module omdfp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire omdfp_pkg::status_type status,
   output omdfp_pkg::cmd_type        cmd
);

   omdfp_pkg::state_type state_ff;
   omdfp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= omdfp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         omdfp_pkg::ST_IDLE: begin
            if (req_valid) state_in = omdfp_pkg::ST_MULT;
         end
         omdfp_pkg::ST_MULT: begin
            state_in = status.is_shift ? omdfp_pkg::ST_SQ_A : omdfp_pkg::ST_WRITE;
         end
         omdfp_pkg::ST_SQ_A:    state_in = omdfp_pkg::ST_TRIAL_A;
         omdfp_pkg::ST_TRIAL_A: state_in = omdfp_pkg::ST_TEST_A;
         omdfp_pkg::ST_TEST_A: begin
            state_in = status.last_bit ? omdfp_pkg::ST_SQ_B : omdfp_pkg::ST_TRIAL_A;
         end
         omdfp_pkg::ST_SQ_B:    state_in = omdfp_pkg::ST_TRIAL_B;
         omdfp_pkg::ST_TRIAL_B: state_in = omdfp_pkg::ST_TEST_B;
         omdfp_pkg::ST_TEST_B: begin
            state_in = status.last_bit ? omdfp_pkg::ST_WRITE : omdfp_pkg::ST_TRIAL_B;
         end
         omdfp_pkg::ST_WRITE: begin
            if (!status.out_busy) state_in = omdfp_pkg::ST_IDLE;
         end
         default: state_in = omdfp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         omdfp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         omdfp_pkg::ST_MULT:    cmd.mult = 1'b1;
         omdfp_pkg::ST_SQ_A:    cmd.square = 1'b1;
         omdfp_pkg::ST_TRIAL_A: cmd.trial = 1'b1;
         omdfp_pkg::ST_TEST_A:  cmd.test = 1'b1;
         omdfp_pkg::ST_SQ_B: begin
            cmd.square = 1'b1;
            cmd.use_b = 1'b1;
         end
         omdfp_pkg::ST_TRIAL_B: begin
            cmd.trial = 1'b1;
            cmd.use_b = 1'b1;
         end
         omdfp_pkg::ST_TEST_B: begin
            cmd.test = 1'b1;
            cmd.use_b = 1'b1;
         end
         omdfp_pkg::ST_WRITE:   cmd.write = !status.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/omdfp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module omdfp_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire omdfp_pkg::cmd_type   cmd,
   output omdfp_pkg::status_type     status,
   input  wire logic [1:0]           req_kind,
   input  wire logic signed [7:0]    req_x_axis,
   input  wire logic signed [7:0]    req_y_axis,
   input  wire logic signed [7:0]    req_speed,
   input  wire logic                 csr_write,
   input  wire logic [6:0]           csr_max_speed,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [63:0]               rsp_frame_payload,
   output logic signed [15:0]        rsp_front_left_cmd,
   output logic signed [15:0]        rsp_back_left_cmd,
   output logic signed [15:0]        rsp_back_right_cmd,
   output logic signed [15:0]        rsp_front_right_cmd
);

   logic [6:0]         max_speed_ff;
   logic [1:0]         kind_ff;
   logic signed [7:0]  x_ff, y_ff, sp_ff;
   logic signed [15:0] num_a_ff, num_b_ff;
   logic [16:0]        d2_ff;
   logic [29:0]        n2_ff;
   logic [6:0]         q_ff, qa_ff;
   logic [2:0]         bit_ff;
   logic [13:0]        sq_ff;
   logic [15:0]        wheel_ff [4];
   logic [15:0]        out_ff [4];
   logic               rsp_valid_ff;

   // front end products
   logic signed [8:0]  sum_xy, diff_yx;
   logic signed [16:0] num_a_full, num_b_full;
   logic signed [15:0] xsq, ysq;
   logic [16:0]        d2_in;
   logic signed [15:0] num_sel, num_abs;
   logic [14:0]        mag;
   logic [29:0]        n2_in;
   logic [6:0]         trial;
   logic [13:0]        sq_in;
   logic [30:0]        prod;
   logic               fits;
   // write back
   logic signed [8:0]  a_pct, b_pct, sp_pct;
   logic [15:0]        wheel_in [4];

   assign sum_xy     = 9'({x_ff[7], x_ff} + {y_ff[7], y_ff});
   assign diff_yx    = 9'({y_ff[7], y_ff} - {x_ff[7], x_ff});
   assign num_a_full = $signed({1'b0, max_speed_ff}) * sum_xy;
   assign num_b_full = $signed({1'b0, max_speed_ff}) * diff_yx;
   assign xsq        = x_ff * x_ff;
   assign ysq        = y_ff * y_ff;
   assign d2_in      = 17'({1'b0, xsq} + {1'b0, ysq}) << 1;

   assign num_sel = cmd.use_b ? num_b_ff : num_a_ff;
   assign num_abs = num_sel[15] ? -num_sel : num_sel;
   assign mag     = num_abs[14:0];
   assign n2_in   = mag * mag;

   // restoring square root of n2 / d2, one quotient bit per trial and test pair
   assign trial = q_ff | (7'd1 << bit_ff);
   assign sq_in = trial * trial;
   assign prod  = sq_ff * d2_ff;
   assign fits  = prod <= {1'b0, n2_ff};

   always_comb begin
      if (d2_ff == '0) begin
         a_pct = '0;
         b_pct = '0;
      end else begin
         a_pct = num_a_ff[15] ? -$signed({2'b0, qa_ff}) : $signed({2'b0, qa_ff});
         b_pct = num_b_ff[15] ? -$signed({2'b0, q_ff}) : $signed({2'b0, q_ff});
      end
   end

   assign sp_pct = {sp_ff[7], sp_ff};

   always_comb begin
      for (int k = 0; k < 4; k++) wheel_in[k] = wheel_ff[k];
      unique case (kind_ff)
         omdfp_pkg::KIND_SHIFT: begin
            wheel_in[0] = omdfp_pkg::pct_to_word(a_pct);
            wheel_in[1] = omdfp_pkg::pct_to_word(b_pct);
            wheel_in[2] = omdfp_pkg::pct_to_word(9'(-a_pct));
            wheel_in[3] = omdfp_pkg::pct_to_word(9'(-b_pct));
         end
         omdfp_pkg::KIND_TURN: begin
            for (int k = 0; k < 4; k++) wheel_in[k] = omdfp_pkg::pct_to_word(sp_pct);
         end
         omdfp_pkg::KIND_TEST: begin
            wheel_in[0] = omdfp_pkg::pct_to_word(sp_pct);
            wheel_in[2] = omdfp_pkg::pct_to_word(9'(-sp_pct));
         end
         default: begin
            // unused kind keeps the words
            for (int k = 0; k < 4; k++) wheel_in[k] = wheel_ff[k];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= omdfp_pkg::MAX_SPEED_RESET;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) wheel_ff[k] <= '0;
      end else begin
         if (csr_write) max_speed_ff <= csr_max_speed;
         if (cmd.write) begin
            rsp_valid_ff <= 1'b1;
            for (int k = 0; k < 4; k++) wheel_ff[k] <= wheel_in[k];
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         x_ff    <= req_x_axis;
         y_ff    <= req_y_axis;
         sp_ff   <= req_speed;
      end
      if (cmd.mult) begin
         num_a_ff <= num_a_full[15:0];
         num_b_ff <= num_b_full[15:0];
         d2_ff    <= d2_in;
      end
      if (cmd.square) begin
         n2_ff  <= n2_in;
         q_ff   <= '0;
         bit_ff <= omdfp_pkg::Q_TOP_BIT;
         if (cmd.use_b) qa_ff <= q_ff;
      end
      if (cmd.trial) sq_ff <= sq_in;
      if (cmd.test) begin
         if (fits) q_ff <= trial;
         bit_ff <= bit_ff - 3'd1;
      end
      if (cmd.write) begin
         for (int k = 0; k < 4; k++) out_ff[k] <= wheel_in[k];
      end
   end

   assign status.is_shift = kind_ff == omdfp_pkg::KIND_SHIFT;
   assign status.last_bit = bit_ff == '0;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_payload   = {out_ff[0], out_ff[1], out_ff[2], out_ff[3]};
   assign rsp_front_left_cmd  = out_ff[0];
   assign rsp_back_left_cmd   = out_ff[1];
   assign rsp_back_right_cmd  = out_ff[2];
   assign rsp_front_right_cmd = out_ff[3];

endmodule
`default_nettype wire

>>> rtl/core/omni_drive_mixer_frame_packer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Four-wheel omni drive mixer: each request (shift by joystick, turn, or test move) updates
// the wheel current words and returns all four with the 8-byte big-endian frame
// (front left, back left, back right, front right). Shift and turn update all four words;
// test move updates front left and back right only, and the unused kind keeps them all.
// A shift request runs through the shared square-root/divide unit, which finds each of
// the two mixing terms one quotient bit at a time (7 bits, a square and a product-compare
// per bit). The result sits in an output register, so the next request is taken while a
// result is still stalled; the block holds in its final step only if the previous
// result has not been taken. The user must write max_speed (reset 100) through the csr port
// only while the block is idle; the block does not enforce it. csr_ready is always high.
module omni_drive_mixer_frame_packer_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [7:0]  req_x_axis,
   input  wire logic signed [7:0]  req_y_axis,
   input  wire logic signed [7:0]  req_speed,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [63:0]             rsp_frame_payload,
   output logic signed [15:0]      rsp_front_left_cmd,
   output logic signed [15:0]      rsp_back_left_cmd,
   output logic signed [15:0]      rsp_back_right_cmd,
   output logic signed [15:0]      rsp_front_right_cmd,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [6:0]         csr_max_speed
);

   omdfp_pkg::cmd_type    cmd;
   omdfp_pkg::status_type status;

   assign csr_ready = 1'b1;

   omdfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   omdfp_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_x_axis          (req_x_axis),
      .req_y_axis          (req_y_axis),
      .req_speed           (req_speed),
      .csr_write           (csr_valid && csr_ready),
      .csr_max_speed       (csr_max_speed),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_frame_payload   (rsp_frame_payload),
      .rsp_front_left_cmd  (rsp_front_left_cmd),
      .rsp_back_left_cmd   (rsp_back_left_cmd),
      .rsp_back_right_cmd  (rsp_back_right_cmd),
      .rsp_front_right_cmd (rsp_front_right_cmd)
   );

endmodule
`default_nettype wire
